// File: rtl/bpit_pkg.sv
// Package for the body pose inverse transform: widths, CORDIC constants,
// angle table and fixed-point helpers. No dependencies.
package bpit_pkg;

    localparam int AngleW  = 16;
    localparam int PosW    = 24;
    localparam int DiffW   = 25;
    localparam int TrigW   = 18;                 // Q16 sin/cos, range +-1
    localparam int CordW   = 33;                 // Q30 x/y with headroom
    localparam int ZW      = 34;                 // 2^32 units per turn, signed
    localparam int AtanN   = 24;
    localparam int DefCordicSteps = 16;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic signed [CordW-1:0] CordicGain = 33'sd652032874;

    typedef logic signed [AngleW-1:0] angle_t;
    typedef logic signed [PosW-1:0]   pos_t;
    typedef logic signed [DiffW-1:0]  diff_t;
    typedef logic signed [TrigW-1:0]  trig_t;

    // One classified angle: scaled reduced angle and half-turn flag
    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } ang_cls_t;

    // Queue entry between front and back
    typedef struct packed {
        ang_cls_t roll;
        ang_cls_t pitch;
        ang_cls_t yaw;
        diff_t    vx;
        diff_t    vy;
        diff_t    vz;
    } work_t;

    function automatic logic signed [ZW-1:0] atan_turns(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = 34'sh020000000;
            1:  r = 34'sh012E4051E;
            2:  r = 34'sh009FB385B;
            3:  r = 34'sh0051111D4;
            4:  r = 34'sh0028B0D43;
            5:  r = 34'sh00145D7E1;
            6:  r = 34'sh000A2F61E;
            7:  r = 34'sh000517C55;
            8:  r = 34'sh00028BE53;
            9:  r = 34'sh000145F2F;
            10: r = 34'sh0000A2F98;
            11: r = 34'sh0000517CC;
            12: r = 34'sh000028BE6;
            13: r = 34'sh0000145F3;
            14: r = 34'sh00000A2FA;
            15: r = 34'sh00000517D;
            16: r = 34'sh0000028BE;
            17: r = 34'sh00000145F;
            18: r = 34'sh000000A30;
            19: r = 34'sh000000518;
            20: r = 34'sh00000028C;
            21: r = 34'sh000000146;
            22: r = 34'sh0000000A3;
            23: r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // (a*b + 2^15) >>> 16 on Q16 values
    function automatic trig_t mul16(input trig_t a, input trig_t b);
        logic signed [2*TrigW-1:0] p;
        p = (2*TrigW)'(a) * (2*TrigW)'(b) + 36'sd32768;
        return trig_t'(p >>> 16);
    endfunction

endpackage

// File: rtl/bpit_front.sv
// Front part: angle reduction and world-minus-shift difference.
// Depends on bpit_pkg.
module bpit_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    output logic           stall,
    input  bpit_pkg::angle_t roll_angle,
    input  bpit_pkg::angle_t pitch_angle,
    input  bpit_pkg::angle_t yaw_angle,
    input  bpit_pkg::pos_t shift_x,
    input  bpit_pkg::pos_t shift_y,
    input  bpit_pkg::pos_t shift_z,
    input  bpit_pkg::pos_t world_x,
    input  bpit_pkg::pos_t world_y,
    input  bpit_pkg::pos_t world_z,
    output logic           q_valid,
    input  logic           q_stall,
    output bpit_pkg::work_t q_data
);
    import bpit_pkg::*;

    work_t data_reg;
    logic  valid_reg;

    function automatic ang_cls_t classify(input angle_t a);
        ang_cls_t c;
        angle_t   r;
        c.neg = 1'b0;
        r = a;
        // adding or subtracting a half turn is the same modulo 2^16
        if (a >= 16'sd16384) begin
            r = a + 16'sh8000;
            c.neg = 1'b1;
        end else if (a < -16'sd16384) begin
            r = a + 16'sh8000;
            c.neg = 1'b1;
        end
        c.z = {{(ZW-AngleW-16){r[AngleW-1]}}, r, 16'h0000};
        return c;
    endfunction

    assign stall   = valid_reg && q_stall;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            data_reg.roll  <= classify(roll_angle);
            data_reg.pitch <= classify(pitch_angle);
            data_reg.yaw   <= classify(yaw_angle);
            data_reg.vx    <= DiffW'(world_x) - DiffW'(shift_x);
            data_reg.vy    <= DiffW'(world_y) - DiffW'(shift_y);
            data_reg.vz    <= DiffW'(world_z) - DiffW'(shift_z);
        end
    end

endmodule

// File: rtl/bpit_queue.sv
// Short FIFO decoupling the front from the back.
// Depends on bpit_pkg.
module bpit_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bpit_pkg::work_t in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output bpit_pkg::work_t out_data
);
    import bpit_pkg::*;

    work_t mem [QueueDepth];
    logic [QueuePtrW-1:0] wr_reg, rd_reg;
    logic [QueuePtrW:0]   cnt_reg;
    logic push, pop;

    assign in_stall  = (cnt_reg == (QueuePtrW+1)'(QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];
    assign push = in_valid && !in_stall;
    assign pop  = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
        end
    end

endmodule

// File: rtl/bpit_back.sv
// Back part: pipelined CORDIC for three angles, rotation matrix and
// transposed product with saturation. Depends on bpit_pkg.
module bpit_back #(
    parameter int CORDIC_STEPS = bpit_pkg::DefCordicSteps
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bpit_pkg::work_t in_data,
    output logic            valid,
    input  logic            stall,
    output bpit_pkg::pos_t  body_x,
    output bpit_pkg::pos_t  body_y,
    output bpit_pkg::pos_t  body_z
);
    import bpit_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int NP = NS + 6;          // total stages incl. output register
    localparam int AccW = 46;

    // stage enable: whole pipe advances together
    logic adv;
    logic [NP-1:0] v_reg;
    assign adv      = !(valid && stall);
    assign in_stall = !adv;
    assign valid    = v_reg[NP-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NP-2:0], in_valid};
        end
    end

    // CORDIC lanes: 0 roll, 1 pitch, 2 yaw
    logic signed [CordW-1:0] cx_reg [3][NS+1];
    logic signed [CordW-1:0] cy_reg [3][NS+1];
    logic signed [ZW-1:0]    cz_reg [3][NS+1];
    logic                    cn_reg [3][NS+1];
    diff_t vx_reg [NS+4], vy_reg [NS+4], vz_reg [NS+4];

    ang_cls_t ang_in [3];
    assign ang_in[0] = in_data.roll;
    assign ang_in[1] = in_data.pitch;
    assign ang_in[2] = in_data.yaw;

    for (genvar l = 0; l < 3; l++) begin : g_load
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[l][0] <= CordicGain;
                cy_reg[l][0] <= '0;
                cz_reg[l][0] <= ang_in[l].z;
                cn_reg[l][0] <= ang_in[l].neg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0] <= in_data.vx;
            vy_reg[0] <= in_data.vy;
            vz_reg[0] <= in_data.vz;
            for (int k = 1; k < NS + 4; k++)
            begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_cord
        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!cz_reg[l][s][ZW-1])
                    begin
                        cx_reg[l][s+1] <= cx_reg[l][s] - (cy_reg[l][s] >>> s);
                        cy_reg[l][s+1] <= cy_reg[l][s] + (cx_reg[l][s] >>> s);
                        cz_reg[l][s+1] <= cz_reg[l][s] - atan_turns(s);
                    end
                    else
                    begin
                        cx_reg[l][s+1] <= cx_reg[l][s] + (cy_reg[l][s] >>> s);
                        cy_reg[l][s+1] <= cy_reg[l][s] - (cx_reg[l][s] >>> s);
                        cz_reg[l][s+1] <= cz_reg[l][s] + atan_turns(s);
                    end
                    cn_reg[l][s+1] <= cn_reg[l][s];
                end
            end
        end
    end

    // Q30 -> Q16 rounding and half-turn negation
    function automatic trig_t to_q16(input logic signed [CordW-1:0] v, input logic neg);
        logic signed [CordW-1:0] t;
        trig_t r;
        t = (v + CordW'(8192)) >>> 14;
        r = trig_t'(t);
        return neg ? -r : r;
    endfunction

    // stage A: sin/cos
    trig_t sn_reg [3], cs_reg [3];
    // stage B: first products
    trig_t cysp_reg, sysp_reg, b_cycp, b_sycp, b_sycr, b_sysr, b_cycr, b_cysr;
    trig_t b_cpsr, b_cpcr, b_sp, b_sr, b_cr;
    // stage C: matrix
    trig_t r_reg [9];
    // stage D: products with v
    logic signed [AccW-1:0] p_reg [9];
    pos_t ox_reg, oy_reg, oz_reg;

    function automatic pos_t sat_out(input logic signed [AccW-1:0] a);
        logic signed [AccW-1:0] b;
        b = (a + AccW'(32768)) >>> 16;
        if (b > AccW'(8388607)) return 24'sh7FFFFF;
        if (b < -AccW'(8388608)) return 24'sh800000;
        return pos_t'(b);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sn_reg[l] <= to_q16(cy_reg[l][NS], cn_reg[l][NS]);
                cs_reg[l] <= to_q16(cx_reg[l][NS], cn_reg[l][NS]);
            end
            cysp_reg <= mul16(cs_reg[2], sn_reg[1]);
            sysp_reg <= mul16(sn_reg[2], sn_reg[1]);
            b_cycp <= mul16(cs_reg[2], cs_reg[1]);
            b_sycp <= mul16(sn_reg[2], cs_reg[1]);
            b_sycr <= mul16(sn_reg[2], cs_reg[0]);
            b_sysr <= mul16(sn_reg[2], sn_reg[0]);
            b_cycr <= mul16(cs_reg[2], cs_reg[0]);
            b_cysr <= mul16(cs_reg[2], sn_reg[0]);
            b_cpsr <= mul16(cs_reg[1], sn_reg[0]);
            b_cpcr <= mul16(cs_reg[1], cs_reg[0]);
            b_sp <= sn_reg[1];
            b_sr <= sn_reg[0];
            b_cr <= cs_reg[0];
            r_reg[0] <= b_cycp;
            r_reg[1] <= mul16(cysp_reg, b_sr) - b_sycr;
            r_reg[2] <= mul16(cysp_reg, b_cr) + b_sysr;
            r_reg[3] <= b_sycp;
            r_reg[4] <= mul16(sysp_reg, b_sr) + b_cycr;
            r_reg[5] <= mul16(sysp_reg, b_cr) - b_cysr;
            r_reg[6] <= -b_sp;
            r_reg[7] <= b_cpsr;
            r_reg[8] <= b_cpcr;
            for (int j = 0; j < 3; j++)
            begin
                p_reg[3*j]   <= AccW'(r_reg[j])   * AccW'(vx_reg[NS+3]);
                p_reg[3*j+1] <= AccW'(r_reg[j+3]) * AccW'(vy_reg[NS+3]);
                p_reg[3*j+2] <= AccW'(r_reg[j+6]) * AccW'(vz_reg[NS+3]);
            end
            ox_reg <= sat_out(p_reg[0] + p_reg[1] + p_reg[2]);
            oy_reg <= sat_out(p_reg[3] + p_reg[4] + p_reg[5]);
            oz_reg <= sat_out(p_reg[6] + p_reg[7] + p_reg[8]);
        end
    end

    assign body_x = ox_reg;
    assign body_y = oy_reg;
    assign body_z = oz_reg;

endmodule

// File: rtl/body_pose_inverse_transform_top.sv
// Body pose inverse transform: foot point from world frame to body frame.
// Input channel: valid/stall with pose angles, translation and world point.
// Output channel: valid/stall with body_x, body_y, body_z (saturated).
// Throughput: one transaction per cycle while the output is not stalled.
// The path from input to output valid runs through the front register, the
// queue, the unrolled CORDIC stages (one per step) and the matrix and
// accumulate stages.
// The back pipeline holds all stages while the output is stalled; the
// four-entry queue then fills and the front stalls the input.
// Reset (rst_n low, asynchronous) empties the queue and all valid bits.
// Depends on bpit_pkg, bpit_front, bpit_queue, bpit_back.
module body_pose_inverse_transform_top #(
    parameter int CORDIC_STEPS = bpit_pkg::DefCordicSteps
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bpit_pkg::angle_t roll_angle,
    input  bpit_pkg::angle_t pitch_angle,
    input  bpit_pkg::angle_t yaw_angle,
    input  bpit_pkg::pos_t   shift_x,
    input  bpit_pkg::pos_t   shift_y,
    input  bpit_pkg::pos_t   shift_z,
    input  bpit_pkg::pos_t   world_x,
    input  bpit_pkg::pos_t   world_y,
    input  bpit_pkg::pos_t   world_z,
    output logic             out_valid,
    input  logic             out_stall,
    output bpit_pkg::pos_t   body_x,
    output bpit_pkg::pos_t   body_y,
    output bpit_pkg::pos_t   body_z
);
    import bpit_pkg::*;

    work_t f_data, b_data;
    logic  f_valid, f_stall, b_valid, b_stall;

    bpit_front u_front (
        .clk, .rst_n,
        .valid(in_valid), .stall(in_stall),
        .roll_angle, .pitch_angle, .yaw_angle,
        .shift_x, .shift_y, .shift_z,
        .world_x, .world_y, .world_z,
        .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
    );

    bpit_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
        .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
    );

    bpit_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk, .rst_n,
        .in_valid(b_valid), .in_stall(b_stall), .in_data(b_data),
        .valid(out_valid), .stall(out_stall),
        .body_x, .body_y, .body_z
    );

endmodule
